// File: design/uart_rm_pkg.sv
// ----------------------------------------------------------------------------
// uart_rm_pkg
// Types and codes for the 16550-style UART register model.
// ----------------------------------------------------------------------------
package uart_rm_pkg;

    localparam int ApbAddrW = 3;
    localparam int ApbDataW = 32;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic [2:0] REG_DATA = 3'd0;
    localparam logic [2:0] REG_IER  = 3'd1;
    localparam logic [2:0] REG_IIR  = 3'd2;
    localparam logic [2:0] REG_LCR  = 3'd3;
    localparam logic [2:0] REG_MCR  = 3'd4;
    localparam logic [2:0] REG_LSR  = 3'd5;
    localparam logic [2:0] REG_MSR  = 3'd6;
    localparam logic [2:0] REG_SCR  = 3'd7;

    localparam logic [15:0] DIVISOR_RESET = 16'(115200 / 9600);

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] reg_index;
        logic [7:0] write_data;
        logic       rx_available;
        logic [7:0] rx_byte;
        logic       rx_more_after;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_loopback;
        logic       rx_take;
        logic       irq;
    } t_out_item;

endpackage

// File: design/uart_16550_register_model.sv
// ----------------------------------------------------------------------------
// uart_16550_register_model
// 16550-style UART register bank without FIFO, one access per transaction.
// ----------------------------------------------------------------------------
// Takes one transaction (register read, register write or tick) per cycle and
// returns its result in the next cycle from an output register; the input side
// stays ready while that register is empty or being drained, so a stalled
// result holds only one slot. Every transaction is a single read-modify-write
// of the register flags. The APB port holds one register, decoded at addresses
// 0 to 3 (paddr[2] low): bit 0 enables copying FCR bits 2:1 into IIR bits 7:6.
module uart_16550_register_model
    import uart_rm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_item            i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ApbAddrW-1:0] paddr,
    input  logic [ApbDataW-1:0] pwdata,
    output logic [ApbDataW-1:0] prdata,
    output logic                pready
);

    logic        r_fifo_en;
    logic [7:0]  r_ier, r_iir, r_lcr, r_mcr, r_lsr, r_msr, r_scr, r_fcr;
    logic        r_dlab, r_irq;
    logic [15:0] r_div;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [7:0]  n_ier, n_iir, n_lcr, n_mcr, n_lsr, n_msr, n_scr, n_fcr;
    logic        n_dlab, n_irq;
    logic [15:0] n_div;
    t_out_item   n_out;
    logic        accept;

    // returns {irq, iir}
    function automatic logic [8:0] f_eval(input logic [7:0] ier, input logic [7:0] iir_in,
                                          input logic [7:0] mcr, input logic avail,
                                          input logic irq_in);
        logic [7:0] iir;
        logic       irq;
        iir = (iir_in & 8'hFB) | {5'b0, avail, 2'b0};
        irq = irq_in;
        if ((ier[1] && iir[1]) || (ier[0] && iir[2])) begin
            iir[0] = 1'b0;
            if (mcr[3]) begin
                irq = 1'b1;
            end
        end else begin
            iir[0] = 1'b1;
            irq    = 1'b0;
        end
        return {irq, iir};
    endfunction

    assign pready      = 1'b1;
    assign prdata      = paddr[2] ? '0 : {{(ApbDataW-1){1'b0}}, r_fifo_en};
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        logic       seen;
        logic       wr;
        n_ier  = r_ier;
        n_iir  = r_iir;
        n_lcr  = r_lcr;
        n_mcr  = r_mcr;
        n_lsr  = r_lsr;
        n_msr  = r_msr;
        n_scr  = r_scr;
        n_fcr  = r_fcr;
        n_dlab = r_dlab;
        n_irq  = r_irq;
        n_div  = r_div;
        n_out  = '0;
        seen   = 1'b0;
        wr     = (i_in.action == ACT_WRITE);
        case (i_in.action)
            ACT_TICK: begin
                {n_irq, n_iir} = f_eval(n_ier, n_iir, n_mcr, i_in.rx_available, n_irq);
            end
            ACT_READ, ACT_WRITE: begin
                n_lsr = ((r_lsr | 8'h60) & 8'hFE) | {7'b0, i_in.rx_available};
                n_msr = r_msr | 8'hB0;
                n_iir = (r_iir & 8'h0F) | (r_fifo_en ? {r_fcr[2:1], 6'b0} : 8'h00);
                if (r_dlab && i_in.reg_index == REG_DATA) begin
                    if (wr) n_div[7:0] = i_in.write_data;
                    else    n_out.read_data = r_div[7:0];
                end else if (r_dlab && i_in.reg_index == REG_IER) begin
                    if (wr) n_div[15:8] = i_in.write_data;
                    else    n_out.read_data = r_div[15:8];
                end else begin
                    case (i_in.reg_index)
                        REG_DATA: begin
                            if (wr) begin
                                n_out.tx_valid    = 1'b1;
                                n_out.tx_byte     = i_in.write_data;
                                n_out.tx_loopback = r_mcr[4];
                                n_iir[1]          = 1'b1;
                                seen = r_mcr[4] | i_in.rx_available;
                            end else if (i_in.rx_available) begin
                                n_out.read_data = i_in.rx_byte;
                                n_out.rx_take   = 1'b1;
                                seen = i_in.rx_more_after;
                            end
                            {n_irq, n_iir} = f_eval(n_ier, n_iir, n_mcr, seen, n_irq);
                        end
                        REG_IER: begin
                            if (wr) begin
                                if (!r_ier[1] && i_in.write_data[1]) n_iir[1] = 1'b1;
                                n_ier = i_in.write_data;
                                {n_irq, n_iir} = f_eval(n_ier, n_iir, n_mcr,
                                                        i_in.rx_available, n_irq);
                            end else begin
                                n_out.read_data = r_ier;
                            end
                        end
                        REG_IIR: begin
                            if (wr) begin
                                n_fcr = i_in.write_data;
                            end else begin
                                n_out.read_data = n_iir;
                                n_iir[1] = 1'b0;
                                {n_irq, n_iir} = f_eval(n_ier, n_iir, n_mcr,
                                                        i_in.rx_available, n_irq);
                            end
                        end
                        REG_LCR: begin
                            if (wr) begin
                                n_lcr  = i_in.write_data;
                                n_dlab = i_in.write_data[7];
                            end else begin
                                n_out.read_data = r_lcr;
                            end
                        end
                        REG_MCR: begin
                            if (wr) begin
                                n_mcr = i_in.write_data;
                                if (i_in.write_data[3]) n_iir[1] = 1'b1;
                                {n_irq, n_iir} = f_eval(n_ier, n_iir, n_mcr,
                                                        i_in.rx_available, n_irq);
                            end else begin
                                n_out.read_data = r_mcr;
                            end
                        end
                        REG_LSR: begin
                            if (wr) n_lsr = i_in.write_data;
                            else    n_out.read_data = n_lsr;
                        end
                        REG_MSR: begin
                            if (wr) n_msr = i_in.write_data;
                            else    n_out.read_data = n_msr;
                        end
                        REG_SCR: begin
                            if (wr) n_scr = i_in.write_data;
                            else    n_out.read_data = r_scr;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
        n_out.irq = n_irq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fifo_en   <= 1'b1;
            r_ier       <= '0;
            r_iir       <= '0;
            r_lcr       <= '0;
            r_mcr       <= '0;
            r_lsr       <= '0;
            r_msr       <= '0;
            r_scr       <= '0;
            r_fcr       <= '0;
            r_dlab      <= 1'b0;
            r_irq       <= 1'b0;
            r_div       <= DIVISOR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (psel && penable && pwrite && !paddr[2]) begin
                r_fifo_en <= pwdata[0];
            end
            if (accept) begin
                r_ier  <= n_ier;
                r_iir  <= n_iir;
                r_lcr  <= n_lcr;
                r_mcr  <= n_mcr;
                r_lsr  <= n_lsr;
                r_msr  <= n_msr;
                r_scr  <= n_scr;
                r_fcr  <= n_fcr;
                r_dlab <= n_dlab;
                r_irq  <= n_irq;
                r_div  <= n_div;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

// File: dv/uart_16550_register_model_tb.sv
// ----------------------------------------------------------------------------
// uart_16550_register_model_tb
// Self-checking bench for the 16550-style UART register bank.
// ----------------------------------------------------------------------------
// Drives register reads, writes, ticks and unused action codes through the
// valid/ready input channel. A scoreboard keeps its own copy of the register
// state and predicts each result, then compares every result field by field.
// Random idle cycles are inserted on both channels. The FIFO-bits enable
// register is written over APB between phases, at both of its values.
// ----------------------------------------------------------------------------
module uart_16550_register_model_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import uart_rm_pkg::*;

    localparam logic [1:0]          ACT_UNUSED         = 2'd3;
    localparam logic [ApbAddrW-1:0] CFG_FIFO_BITS_ADDR = '0;
    localparam int                  STALL_LIMIT        = 5000;
    localparam int                  PRINT_LIMIT        = 50;

    class uart_reg_scoreboard;
        logic [7:0]  bank [8];
        logic [7:0]  fcr_shadow;
        logic        dlab;
        logic [15:0] divisor;
        logic        irq_line;
        logic        fifo_bits_on;
        t_out_item   expected_results[$];
        int          errors;

        function new();
            foreach (bank[i]) bank[i] = '0;
            fcr_shadow   = '0;
            dlab         = 1'b0;
            divisor      = DIVISOR_RESET;
            irq_line     = 1'b0;
            fifo_bits_on = 1'b1;
            errors       = 0;
        endfunction

        function void set_fifo_bits(logic value);
            fifo_bits_on = value;
        endfunction

        function void update_irq(logic avail);
            logic [7:0] iir;
            iir    = bank[REG_IIR];
            iir[2] = avail;
            if ((bank[REG_IER][1] && iir[1]) || (bank[REG_IER][0] && iir[2])) begin
                iir[0] = 1'b0;
                if (bank[REG_MCR][3]) irq_line = 1'b1;
            end else begin
                iir[0]   = 1'b1;
                irq_line = 1'b0;
            end
            bank[REG_IIR] = iir;
        endfunction

        function t_out_item predict_access(t_in_item it);
            t_out_item r;
            logic      wr;
            logic      seen;
            r  = '0;
            wr = (it.action == ACT_WRITE);
            if (it.action == ACT_TICK) begin
                update_irq(it.rx_available);
            end else if (it.action == ACT_READ || it.action == ACT_WRITE) begin
                bank[REG_LSR] = bank[REG_LSR] | 8'h60;
                bank[REG_MSR] = bank[REG_MSR] | 8'hB0;
                bank[REG_IIR] = bank[REG_IIR] & 8'h0F;
                if (fifo_bits_on) bank[REG_IIR][7:6] = fcr_shadow[2:1];
                bank[REG_LSR][0] = it.rx_available;
                if (dlab && it.reg_index == REG_DATA) begin
                    if (wr) divisor[7:0] = it.write_data;
                    else r.read_data = divisor[7:0];
                end else if (dlab && it.reg_index == REG_IER) begin
                    if (wr) divisor[15:8] = it.write_data;
                    else r.read_data = divisor[15:8];
                end else begin
                    case (it.reg_index)
                        REG_DATA: begin
                            if (wr) begin
                                r.tx_valid    = 1'b1;
                                r.tx_byte     = it.write_data;
                                r.tx_loopback = bank[REG_MCR][4];
                                bank[REG_IIR][1] = 1'b1;
                                seen = r.tx_loopback ? 1'b1 : it.rx_available;
                            end else if (it.rx_available) begin
                                r.read_data = it.rx_byte;
                                r.rx_take   = 1'b1;
                                seen = it.rx_more_after;
                            end else begin
                                seen = 1'b0;
                            end
                            update_irq(seen);
                        end
                        REG_IER: begin
                            if (wr) begin
                                if (!bank[REG_IER][1] && it.write_data[1])
                                    bank[REG_IIR][1] = 1'b1;
                                bank[REG_IER] = it.write_data;
                                update_irq(it.rx_available);
                            end else begin
                                r.read_data = bank[REG_IER];
                            end
                        end
                        REG_IIR: begin
                            if (wr) begin
                                fcr_shadow = it.write_data;
                            end else begin
                                r.read_data = bank[REG_IIR];
                                bank[REG_IIR][1] = 1'b0;
                                update_irq(it.rx_available);
                            end
                        end
                        REG_LCR: begin
                            if (wr) begin
                                bank[REG_LCR] = it.write_data;
                                dlab = it.write_data[7];
                            end else begin
                                r.read_data = bank[REG_LCR];
                            end
                        end
                        REG_MCR: begin
                            if (wr) begin
                                bank[REG_MCR] = it.write_data;
                                if (it.write_data[3]) bank[REG_IIR][1] = 1'b1;
                                update_irq(it.rx_available);
                            end else begin
                                r.read_data = bank[REG_MCR];
                            end
                        end
                        default: begin
                            if (wr) bank[it.reg_index] = it.write_data;
                            else r.read_data = bank[it.reg_index];
                        end
                    endcase
                end
            end
            r.irq = irq_line;
            return r;
        endfunction

        function void note_access(t_in_item it);
            expected_results.push_back(predict_access(it));
        endfunction

        task report_mismatch(string what, int got, int exp);
            if (errors < PRINT_LIMIT)
                $display("ERROR @%0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, exp);
            errors++;
        endtask

        task check_result(t_out_item got);
            t_out_item exp;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", got, 0);
                return;
            end
            exp = expected_results.pop_front();
            if (got.read_data !== exp.read_data)
                report_mismatch("read_data", got.read_data, exp.read_data);
            if (got.tx_valid !== exp.tx_valid)
                report_mismatch("tx_valid", got.tx_valid, exp.tx_valid);
            if (got.tx_byte !== exp.tx_byte)
                report_mismatch("tx_byte", got.tx_byte, exp.tx_byte);
            if (got.tx_loopback !== exp.tx_loopback)
                report_mismatch("tx_loopback", got.tx_loopback, exp.tx_loopback);
            if (got.rx_take !== exp.rx_take)
                report_mismatch("rx_take", got.rx_take, exp.rx_take);
            if (got.irq !== exp.irq)
                report_mismatch("irq", got.irq, exp.irq);
        endtask

        task close_out();
            if (expected_results.size() != 0)
                report_mismatch("results never returned", 0, expected_results.size());
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n    = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    t_in_item            in_data    = '0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    t_out_item           out_data;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [ApbAddrW-1:0] paddr      = '0;
    logic [ApbDataW-1:0] pwdata     = '0;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    uart_reg_scoreboard sb = new();
    int                 idle_pct     = 34;
    int                 stall_cycles = 0;

    uart_16550_register_model dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) sb.check_result(out_data);
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_in_item make_access(logic [1:0] action, logic [2:0] idx,
                                             logic [7:0] wd, logic avail = 1'b0,
                                             logic [7:0] rxb = '0, logic more = 1'b0);
        t_in_item it;
        it.action        = action;
        it.reg_index     = idx;
        it.write_data    = wd;
        it.rx_available  = avail;
        it.rx_byte       = rxb;
        it.rx_more_after = more;
        return it;
    endfunction

    function automatic t_in_item random_access();
        t_in_item it;
        int       pick;
        pick = $urandom_range(99);
        it   = t_in_item'($urandom);
        if (pick < 45) it.action = ACT_READ;
        else if (pick < 85) it.action = ACT_WRITE;
        else if (pick < 98) it.action = ACT_TICK;
        else it.action = ACT_UNUSED;
        it.reg_index  = 3'($urandom_range(7));
        it.write_data = 8'($urandom_range(255));
        // keep the divisor latch closed most of the time
        if (it.action == ACT_WRITE && it.reg_index == REG_LCR && $urandom_range(3) != 0)
            it.write_data[7] = 1'b0;
        return it;
    endfunction

    task automatic send_access(input t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        sb.note_access(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [ApbAddrW-1:0] addr, input logic [ApbDataW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == CFG_FIFO_BITS_ADDR) sb.set_fifo_bits(data[0]);
    endtask

    task automatic random_phase(input int count, input int calm_from, input int calm_to);
        for (int n = 0; n < count; n++) begin
            idle_pct = (n >= calm_from && n < calm_to) ? 0 : 34;
            send_access(random_access());
        end
        idle_pct = 34;
    endtask

    initial begin
        t_in_item directed[$];

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed = '{
            make_access(ACT_READ,   REG_IIR,  8'h00),
            make_access(ACT_READ,   REG_LSR,  8'h00, 1'b1),
            make_access(ACT_WRITE,  REG_LCR,  8'h83),
            make_access(ACT_WRITE,  REG_DATA, 8'hFF),
            make_access(ACT_WRITE,  REG_IER,  8'h00),
            make_access(ACT_READ,   REG_DATA, 8'h00, 1'b1, 8'h55, 1'b1),
            make_access(ACT_READ,   REG_IER,  8'h00),
            make_access(ACT_WRITE,  REG_LCR,  8'h03),
            make_access(ACT_WRITE,  REG_IIR,  8'h06),
            make_access(ACT_READ,   REG_IIR,  8'h00),
            make_access(ACT_WRITE,  REG_IER,  8'h03),
            make_access(ACT_WRITE,  REG_MCR,  8'h18),
            make_access(ACT_WRITE,  REG_DATA, 8'hA5),
            make_access(ACT_READ,   REG_IIR,  8'h00),
            make_access(ACT_WRITE,  REG_MCR,  8'h08),
            make_access(ACT_WRITE,  REG_DATA, 8'h00),
            make_access(ACT_READ,   REG_DATA, 8'h00, 1'b1, 8'hFF, 1'b1),
            make_access(ACT_READ,   REG_DATA, 8'h00, 1'b0, 8'hFF, 1'b1),
            make_access(ACT_TICK,   REG_SCR,  8'h00, 1'b1),
            make_access(ACT_TICK,   REG_DATA, 8'hFF, 1'b0),
            make_access(ACT_WRITE,  REG_SCR,  8'hFF),
            make_access(ACT_READ,   REG_SCR,  8'h00),
            make_access(ACT_WRITE,  REG_LSR,  8'h00),
            make_access(ACT_READ,   REG_LSR,  8'h00),
            make_access(ACT_WRITE,  REG_MSR,  8'hFF),
            make_access(ACT_READ,   REG_MSR,  8'h00),
            make_access(ACT_UNUSED, REG_MCR,  8'hFF, 1'b1, 8'hFF, 1'b1)
        };
        foreach (directed[i]) send_access(directed[i]);
        drain();

        apb_write(CFG_FIFO_BITS_ADDR, 32'd0);
        random_phase(550, 0, 0);
        drain();

        apb_write(CFG_FIFO_BITS_ADDR, 32'd1);
        random_phase(650, 200, 420);
        drain();

        apb_write(CFG_FIFO_BITS_ADDR, 32'd0);
        random_phase(250, 0, 0);
        drain();

        apb_write(CFG_FIFO_BITS_ADDR, 32'd1);
        random_phase(250, 0, 0);
        drain();

        repeat (8) @(posedge i_clk);
        sb.close_out();
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
